>>> rtl/mlfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfs_pkg: shared definitions of the memory LCD frame buffer serializer
// Geometry of the frame store, protocol bytes, action codes and the command
// word that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package mlfs_pkg;

    localparam int WIDTH       = 320;
    localparam int HEIGHT      = 240;
    localparam int LINE_BYTES  = WIDTH / 8;
    localparam int STORE_BYTES = (WIDTH * HEIGHT + 7) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int LIN_W       = $clog2(256 * WIDTH + 512);
    localparam int CNT_W       = $clog2(LINE_BYTES + 1);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0] CMD_WRITE = 8'h01;
    localparam logic [7:0] CMD_CLEAR = 8'h04;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [2:0] {
        ACT_SET   = 3'd0,
        ACT_READ  = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_LINE  = 3'd3,
        ACT_CLEAR = 3'd4,
        ACT_FILL  = 3'd5
    } act_t;

    typedef struct packed {
        act_t              act;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
        logic              color;
        logic [7:0]        data;
        logic [7:0]        line_num;
        logic              first;
        logic              lastl;
        logic              hit;
    } cmd_t;

endpackage
`default_nettype wire

>>> rtl/mlfs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfs_front: input decoder
// Accepts input words, checks their coordinates against the frame geometry,
// works out store addresses and passes the commands that have an effect on.
// ----------------------------------------------------------------------------
module mlfs_front (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [39:0]   s_tdata,   // x, y, color, column, data_byte, first_line
    input  wire logic [2:0]    s_tuser,   // action
    input  wire logic          s_tlast,   // final_line
    input  wire logic          run_ok,
    output mlfs_pkg::cmd_t     cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready
);

    logic [8:0]                 x;
    logic [7:0]                 y;
    logic [5:0]                 column;
    mlfs_pkg::act_t             act;
    logic [mlfs_pkg::LIN_W-1:0] y_lin;
    logic [mlfs_pkg::LIN_W-1:0] pix_lin;
    logic [mlfs_pkg::LIN_W-1:0] wb_lin;
    logic [mlfs_pkg::LIN_W-1:0] line_base;
    logic                       x_ok;
    logic                       y_ok;
    logic                       col_ok;
    logic                       keep;

    assign x      = s_tdata[8:0];
    assign y      = s_tdata[16:9];
    assign column = s_tdata[23:18];
    assign act    = mlfs_pkg::act_t'(s_tuser);

    assign y_lin     = mlfs_pkg::LIN_W'(y) * mlfs_pkg::LIN_W'(mlfs_pkg::WIDTH);
    assign pix_lin   = y_lin + mlfs_pkg::LIN_W'(x);
    assign wb_lin    = y_lin + mlfs_pkg::LIN_W'({column, 3'b000});
    assign line_base = mlfs_pkg::LIN_W'(y) * mlfs_pkg::LIN_W'(mlfs_pkg::LINE_BYTES);

    assign x_ok   = {1'b0, x} < 10'(mlfs_pkg::WIDTH);
    assign y_ok   = y < 8'(mlfs_pkg::HEIGHT);
    assign col_ok = {1'b0, column} < 7'(mlfs_pkg::LINE_BYTES);

    always_comb begin
        cmd          = '0;
        cmd.act      = act;
        cmd.bit_sel  = x[2:0];
        cmd.color    = s_tdata[17];
        cmd.data     = s_tdata[31:24];
        cmd.line_num = y + 8'd1;
        cmd.first    = s_tdata[32];
        cmd.lastl    = s_tlast;
        cmd.hit      = x_ok && y_ok;
        keep         = 1'b0;
        unique case (act)
            mlfs_pkg::ACT_SET: begin
                keep     = x_ok && y_ok;
                cmd.addr = mlfs_pkg::ADDR_W'(pix_lin >> 3);
            end
            mlfs_pkg::ACT_READ: begin
                keep     = 1'b1;
                cmd.addr = mlfs_pkg::ADDR_W'(pix_lin >> 3);
            end
            mlfs_pkg::ACT_WRITE: begin
                keep     = col_ok && y_ok;
                cmd.addr = mlfs_pkg::ADDR_W'(wb_lin >> 3);
            end
            mlfs_pkg::ACT_LINE: begin
                keep     = y_ok;
                cmd.addr = mlfs_pkg::ADDR_W'(line_base);
            end
            mlfs_pkg::ACT_CLEAR,
            mlfs_pkg::ACT_FILL: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Words without an effect are taken and dropped here.
    assign s_tready  = run_ok && cmd_ready;
    assign cmd_valid = s_tvalid && s_tready && keep;

endmodule
`default_nettype wire

>>> rtl/mlfs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfs_queue: command queue
// A short first-in first-out queue of decoded commands between the front end
// and the back end.
// ----------------------------------------------------------------------------
module mlfs_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  mlfs_pkg::cmd_t      wr_cmd,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    output mlfs_pkg::cmd_t      rd_cmd,
    output logic                rd_valid,
    input  wire logic           rd_ready
);

    mlfs_pkg::cmd_t              slot_reg [mlfs_pkg::QDEPTH];
    logic [mlfs_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [mlfs_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [mlfs_pkg::QCNT_W-1:0] count_reg;
    logic                        do_wr;
    logic                        do_rd;

    assign wr_ready = count_reg != mlfs_pkg::QCNT_W'(mlfs_pkg::QDEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_ready && rd_valid;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/mlfs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfs_back: frame store and serial sequencer
// Holds the frame store, carries out commands one at a time and drives the
// result register towards the panel side.
// ----------------------------------------------------------------------------
module mlfs_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  mlfs_pkg::cmd_t     q_cmd,
    input  wire logic          q_valid,
    output logic               q_pop,
    output logic               run_ok,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata,   // out_byte, pixel_value, end_of_transfer
    output logic               m_tuser,   // kind
    output logic               m_tlast    // last
);

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_SET_WR,
        S_READ_ANS,
        S_LINE_CMD,
        S_LINE_NUM,
        S_LINE_DATA,
        S_LINE_END,
        S_CLR_CMD,
        S_TAIL
    } state_t;

    localparam logic [mlfs_pkg::ADDR_W-1:0] PTR_LAST =
        mlfs_pkg::ADDR_W'(mlfs_pkg::STORE_BYTES - 1);
    // A line send leaves the pointer one past the last byte that it fetched.
    localparam logic [mlfs_pkg::ADDR_W-1:0] PTR_END =
        mlfs_pkg::ADDR_W'(mlfs_pkg::STORE_BYTES);
    localparam logic [mlfs_pkg::CNT_W-1:0]  CNT_LAST = mlfs_pkg::CNT_W'(mlfs_pkg::LINE_BYTES - 1);

    logic [7:0]                  frame_mem [mlfs_pkg::STORE_BYTES];
    logic [7:0]                  rd_q;

    state_t                      state_reg, state_next;
    logic [mlfs_pkg::ADDR_W-1:0] ptr_reg, ptr_next;
    logic [mlfs_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    mlfs_pkg::cmd_t              cmd_reg, cmd_next;
    logic                        clr_reg, clr_next;
    logic                        boot_reg, boot_next;

    logic                        valid_reg;
    logic [7:0]                  byte_reg;
    logic                        pix_reg;
    logic                        kind_reg;
    logic                        last_reg;
    logic                        eot_reg;

    logic                        out_free;
    logic                        emit;
    logic                        e_kind;
    logic [7:0]                  e_byte;
    logic                        e_pix;
    logic                        e_last;
    logic                        e_eot;

    logic                        mem_we;
    logic [mlfs_pkg::ADDR_W-1:0] mem_wa;
    logic [7:0]                  mem_wd;
    logic                        mem_re;
    logic [mlfs_pkg::ADDR_W-1:0] mem_ra;
    logic [7:0]                  bit_mask;

    assign out_free = !valid_reg || m_tready;
    assign bit_mask = 8'd1 << cmd_reg.bit_sel;
    assign run_ok   = !boot_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_q <= frame_mem[mem_ra];
        end
    end

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        clr_next   = clr_reg;
        boot_next  = boot_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = ptr_reg;
        mem_wd     = mlfs_pkg::BYTE_ONES;
        mem_re     = 1'b0;
        mem_ra     = ptr_reg;
        emit       = 1'b0;
        e_kind     = 1'b0;
        e_byte     = mlfs_pkg::BYTE_ZERO;
        e_pix      = 1'b0;
        e_last     = 1'b0;
        e_eot      = 1'b0;
        unique case (state_reg)
            S_SWEEP: begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == PTR_LAST) begin
                    ptr_next   = '0;
                    boot_next  = 1'b0;
                    state_next = clr_reg ? S_CLR_CMD : S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.act)
                        mlfs_pkg::ACT_SET: begin
                            mem_re     = 1'b1;
                            mem_ra     = q_cmd.addr;
                            state_next = S_SET_WR;
                        end
                        mlfs_pkg::ACT_READ: begin
                            mem_re     = q_cmd.hit;
                            mem_ra     = q_cmd.addr;
                            state_next = S_READ_ANS;
                        end
                        mlfs_pkg::ACT_WRITE: begin
                            mem_we = 1'b1;
                            mem_wa = q_cmd.addr;
                            mem_wd = q_cmd.data;
                        end
                        mlfs_pkg::ACT_LINE: begin
                            ptr_next   = q_cmd.addr;
                            cnt_next   = '0;
                            state_next = q_cmd.first ? S_LINE_CMD : S_LINE_NUM;
                        end
                        mlfs_pkg::ACT_CLEAR: begin
                            clr_next   = 1'b1;
                            ptr_next   = '0;
                            state_next = S_SWEEP;
                        end
                        mlfs_pkg::ACT_FILL: begin
                            clr_next   = 1'b0;
                            ptr_next   = '0;
                            state_next = S_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SET_WR: begin
                mem_we     = 1'b1;
                mem_wa     = cmd_reg.addr;
                mem_wd     = cmd_reg.color ? (rd_q | bit_mask) : (rd_q & ~bit_mask);
                state_next = S_IDLE;
            end
            S_READ_ANS: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = 1'b1;
                    e_pix      = cmd_reg.hit && rd_q[cmd_reg.bit_sel];
                    e_last     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LINE_CMD: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_byte     = mlfs_pkg::CMD_WRITE;
                    state_next = S_LINE_NUM;
                end
            end
            S_LINE_NUM: begin
                // The first line byte is fetched while the address goes out.
                if (out_free) begin
                    emit       = 1'b1;
                    e_byte     = cmd_reg.line_num;
                    mem_re     = 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_LINE_DATA;
                end
            end
            S_LINE_DATA: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_byte = rd_q;
                    if (cnt_reg == CNT_LAST) begin
                        state_next = S_LINE_END;
                    end else begin
                        mem_re   = 1'b1;
                        ptr_next = ptr_reg + 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_LINE_END: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_last     = !cmd_reg.lastl;
                    state_next = cmd_reg.lastl ? S_TAIL : S_IDLE;
                end
            end
            S_CLR_CMD: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_byte     = mlfs_pkg::CMD_CLEAR;
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_last     = 1'b1;
                    e_eot      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            clr_reg   <= 1'b0;
            boot_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            boot_reg  <= boot_next;
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
        cmd_reg <= cmd_next;
        if (emit) begin
            byte_reg <= e_byte;
            pix_reg  <= e_pix;
            kind_reg <= e_kind;
            last_reg <= e_last;
            eot_reg  <= e_eot;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b000000, eot_reg, pix_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_ptr_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PTR_END)
        else $error("store pointer beyond the end of the frame store");

    a_cnt_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_LAST)
        else $error("line byte count beyond the line length");

    a_one_port_use: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("frame store read and written in the same cycle");

    a_boot_sweeps: assert property (@(posedge aclk) disable iff (!aresetn)
        boot_reg |-> (state_reg == S_SWEEP && !q_pop))
        else $error("command taken before the store was initialised");

    a_line_emits_fetched: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LINE_NUM && emit) |=> (state_reg == S_LINE_DATA))
        else $error("line address sent without moving on to the line bytes");
`endif

endmodule
`default_nettype wire

>>> rtl/memory_lcd_framebuffer_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// memory_lcd_framebuffer_serializer: memory LCD frame store and line writer
//
// Channel  Dir  tdata (low bit up)                                 tuser   tlast
// s_       in   x, y, color, column, data_byte, first_line        action  final_line
// m_       out  out_byte, pixel_value, end_of_transfer            kind    last
//
// After reset the store is swept to all ones, one byte a cycle;
// no word is taken until the sweep is over.
// Set pixel reads the store byte and writes it back; a line send puts out 42 to 44
// serial bytes, one a cycle while m_tready allows, from the single store read port;
// fill and clear each run the store sweep.
// A two-entry command queue lets words be taken while results wait on m_tready.
// ----------------------------------------------------------------------------
module memory_lcd_framebuffer_serializer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // x, y, color, column, data_byte, first_line
    input  wire logic [2:0]  s_tuser,   // action
    input  wire logic        s_tlast,   // final_line
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // out_byte, pixel_value, end_of_transfer
    output logic             m_tuser,   // kind
    output logic             m_tlast    // last
);

    mlfs_pkg::cmd_t front_cmd;
    logic           front_valid;
    logic           q_ready;
    mlfs_pkg::cmd_t q_cmd;
    logic           q_valid;
    logic           q_pop;
    logic           run_ok;

    mlfs_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .run_ok    (run_ok),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (q_ready)
    );

    mlfs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_cmd   (front_cmd),
        .wr_valid (front_valid),
        .wr_ready (q_ready),
        .rd_cmd   (q_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_pop)
    );

    mlfs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_cmd    (q_cmd),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .run_ok   (run_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

>>> dv/memory_lcd_framebuffer_serializer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memory_lcd_framebuffer_serializer_tb: self-checking bench for the frame
// store and line serializer
// A scoreboard keeps its own copy of the one-bit-per-pixel frame store and
// predicts the pixel answers and serial line and clear bytes of each word
// taken on s_. Results on m_ are checked in order against that prediction.
// A directed burst covers the corners and ignored cases, and random traffic
// follows with varying gaps on s_ and varying back-pressure on m_.
// ----------------------------------------------------------------------------
module memory_lcd_framebuffer_serializer_tb;

    localparam int NUM_WORDS    = 325;
    localparam int STALL_LIMIT  = 100000;  // longer than a store sweep with nothing moving
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    // Action codes with no meaning in the block; they must be swallowed.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0] action;
        logic [8:0] x;
        logic [7:0] y;
        logic       color;
        logic [5:0] column;
        logic [7:0] data_byte;
        logic       first_line;
        logic       final_line;
    } lcd_word_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic       pixel_value;
        logic       last;
        logic       end_of_transfer;
    } lcd_result_t;

    class lcd_scoreboard;
        bit [7:0]    pixels [mlfs_pkg::STORE_BYTES];
        lcd_result_t panel_bytes_q [$];
        int          mismatches;
        int          words_noted;
        int          results_seen;
        int          line_sends;
        int          pixel_reads;
        int          store_sweeps;

        function new();
            fill_ones();
        endfunction

        function void fill_ones();
            foreach (pixels[i]) pixels[i] = mlfs_pkg::BYTE_ONES;
        endfunction

        function void queue_result(logic kind, logic [7:0] out_byte, logic pix,
                                   logic last, logic eot);
            panel_bytes_q.push_back('{kind, out_byte, pix, last, eot});
        endfunction

        function void flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
        endfunction

        function int pending();
            return panel_bytes_q.size();
        endfunction

        // Applies one accepted word to the store copy and queues its results.
        function void note_word(lcd_word_t w);
            int  addr;
            int  base;
            bit  pix_ok;
            words_noted++;
            pix_ok = (w.x < mlfs_pkg::WIDTH) && (w.y < mlfs_pkg::HEIGHT);
            addr   = (int'(w.y) * mlfs_pkg::WIDTH + int'(w.x)) / 8;
            case (w.action)
                mlfs_pkg::ACT_SET: begin
                    if (pix_ok) pixels[addr][w.x[2:0]] = w.color;
                end
                mlfs_pkg::ACT_READ: begin
                    pixel_reads++;
                    queue_result(1'b1, mlfs_pkg::BYTE_ZERO,
                                 pix_ok ? pixels[addr][w.x[2:0]] : 1'b0,
                                 1'b1, 1'b0);
                end
                mlfs_pkg::ACT_WRITE: begin
                    if (w.column < mlfs_pkg::LINE_BYTES && w.y < mlfs_pkg::HEIGHT)
                        pixels[int'(w.y) * mlfs_pkg::LINE_BYTES + int'(w.column)] =
                            w.data_byte;
                end
                mlfs_pkg::ACT_LINE: begin
                    if (w.y < mlfs_pkg::HEIGHT) begin
                        line_sends++;
                        base = int'(w.y) * mlfs_pkg::LINE_BYTES;
                        if (w.first_line)
                            queue_result(1'b0, mlfs_pkg::CMD_WRITE, 1'b0, 1'b0, 1'b0);
                        queue_result(1'b0, w.y + 8'd1, 1'b0, 1'b0, 1'b0);
                        for (int i = 0; i < mlfs_pkg::LINE_BYTES; i++)
                            queue_result(1'b0, pixels[base + i], 1'b0, 1'b0, 1'b0);
                        queue_result(1'b0, mlfs_pkg::BYTE_ZERO, 1'b0, !w.final_line, 1'b0);
                        if (w.final_line)
                            queue_result(1'b0, mlfs_pkg::BYTE_ZERO, 1'b0, 1'b1, 1'b1);
                    end
                end
                mlfs_pkg::ACT_CLEAR: begin
                    store_sweeps++;
                    fill_ones();
                    queue_result(1'b0, mlfs_pkg::CMD_CLEAR, 1'b0, 1'b0, 1'b0);
                    queue_result(1'b0, mlfs_pkg::BYTE_ZERO, 1'b0, 1'b1, 1'b1);
                end
                mlfs_pkg::ACT_FILL: begin
                    store_sweeps++;
                    fill_ones();
                end
                default: ;
            endcase
        endfunction

        function void check_result(lcd_result_t got);
            lcd_result_t want;
            results_seen++;
            if (panel_bytes_q.size() == 0) begin
                flag_mismatch($sformatf(
                    "unexpected result kind=%0d byte=%02h pix=%0d last=%0d eot=%0d",
                    got.kind, got.out_byte, got.pixel_value, got.last,
                    got.end_of_transfer));
                return;
            end
            want = panel_bytes_q.pop_front();
            if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                got.pixel_value !== want.pixel_value || got.last !== want.last ||
                got.end_of_transfer !== want.end_of_transfer)
                flag_mismatch($sformatf({"result %0d: kind %0d/%0d byte %02h/%02h ",
                    "pix %0d/%0d last %0d/%0d eot %0d/%0d (exp/act)"},
                    results_seen, want.kind, got.kind, want.out_byte, got.out_byte,
                    want.pixel_value, got.pixel_value, want.last, got.last,
                    want.end_of_transfer, got.end_of_transfer));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    lcd_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int quiet_cycles = 0;

    memory_lcd_framebuffer_serializer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic lcd_word_t mk_word(logic [2:0] action, int x, int y, bit color,
                                          int column, int data_byte, bit first_line,
                                          bit final_line);
        lcd_word_t w;
        w.action     = action;
        w.x          = 9'(x);
        w.y          = 8'(y);
        w.color      = color;
        w.column     = 6'(column);
        w.data_byte  = 8'(data_byte);
        w.first_line = first_line;
        w.final_line = final_line;
        return w;
    endfunction

    // Offers one word from a falling edge and returns at the falling edge
    // after it has been taken.
    task automatic send_word(lcd_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, w.first_line, w.data_byte, w.column, w.color, w.y, w.x};
        s_tuser  <= w.action;
        s_tlast  <= w.final_line;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(w);
        @(negedge aclk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin : receiver
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                for (int i = 1; i < HOLD_CYCLES; i++) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{m_tuser, m_tdata[7:0], m_tdata[8], m_tlast, m_tdata[9]});
    end

    // Watchdog: the store sweeps are the longest legal stretch without a word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        lcd_word_t w;
        int        counted;
        int        pick;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        s_tlast       = 1'b0;
        aresetn       = 1'b0;
        hold_request  = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 51;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Corners of the store and the ignored cases first.
        send_word(mk_word(mlfs_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_SET, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_READ, 0, 0, 1, 63, 255, 1, 1));
        send_word(mk_word(mlfs_pkg::ACT_SET, mlfs_pkg::WIDTH - 1, mlfs_pkg::HEIGHT - 1,
                          0, 63, 255, 1, 1));
        send_word(mk_word(mlfs_pkg::ACT_READ, mlfs_pkg::WIDTH - 1, mlfs_pkg::HEIGHT - 1,
                          0, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_SET, mlfs_pkg::WIDTH, 0, 0, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_READ, 511, 255, 1, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_READ, 0, mlfs_pkg::HEIGHT, 0, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_SET, 0, 0, 1, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_WRITE, 0, 0, 0, 0, 8'h00, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_WRITE, 0, mlfs_pkg::HEIGHT - 1, 0,
                          mlfs_pkg::LINE_BYTES - 1, 8'hA5, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_WRITE, 0, 255, 0, 63, 8'h00, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_WRITE, 0, 0, 0, mlfs_pkg::LINE_BYTES, 8'h0F, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_LINE, 0, 0, 0, 0, 0, 1, 0));
        send_word(mk_word(mlfs_pkg::ACT_LINE, 0, mlfs_pkg::HEIGHT - 1, 0, 0, 0, 0, 1));
        send_word(mk_word(mlfs_pkg::ACT_LINE, 0, 255, 0, 0, 0, 1, 1));
        send_word(mk_word(mlfs_pkg::ACT_LINE, 0, mlfs_pkg::HEIGHT, 0, 0, 0, 0, 0));
        send_word(mk_word(ACT_SPARE_LO, 7, 7, 1, 7, 7, 1, 1));
        send_word(mk_word(ACT_SPARE_HI, 7, 7, 1, 7, 7, 1, 1));
        send_word(mk_word(mlfs_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_READ, mlfs_pkg::WIDTH - 1, mlfs_pkg::HEIGHT - 1,
                          0, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_SET, 5, 5, 0, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_FILL, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_READ, 5, 5, 0, 0, 0, 0, 0));
        send_word(mk_word(mlfs_pkg::ACT_LINE, 0, 0, 0, 0, 0, 1, 1));

        // Random traffic, mostly confined to a few lines at the top and the
        // bottom of the panel so that line sends carry recently drawn pixels.
        counted = 0;
        while (counted < NUM_WORDS) begin
            if (counted == NUM_WORDS / 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 28;
            end else if (counted == 2 * NUM_WORDS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (counted == 250) hold_request = 1'b1;

            w.x          = 9'($urandom_range(mlfs_pkg::WIDTH - 1));
            w.y          = ($urandom_range(99) < 80)
                         ? ($urandom_range(1) ? 8'($urandom_range(3))
                                              : 8'(mlfs_pkg::HEIGHT - 4 + $urandom_range(3)))
                         : 8'($urandom_range(mlfs_pkg::HEIGHT - 1));
            w.color      = 1'($urandom_range(1));
            w.column     = 6'($urandom_range(mlfs_pkg::LINE_BYTES - 1));
            w.data_byte  = 8'($urandom_range(255));
            w.first_line = 1'($urandom_range(1));
            w.final_line = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 24)      w.action = mlfs_pkg::ACT_SET;
            else if (pick < 48) w.action = mlfs_pkg::ACT_READ;
            else if (pick < 68) w.action = mlfs_pkg::ACT_WRITE;
            else if (pick < 86) w.action = mlfs_pkg::ACT_LINE;
            else if (pick < 88) w.action = mlfs_pkg::ACT_CLEAR;
            else if (pick < 90) w.action = mlfs_pkg::ACT_FILL;
            else if (pick < 93) w.action = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
            else begin
                // Out of range on a pixel or byte action or a line send.
                w.action = 3'($urandom_range(int'(mlfs_pkg::ACT_LINE)));
                if ($urandom_range(1)) begin
                    w.x      = 9'($urandom_range(511, mlfs_pkg::WIDTH));
                    w.column = 6'($urandom_range(63, mlfs_pkg::LINE_BYTES));
                end else begin
                    w.y = 8'($urandom_range(255, mlfs_pkg::HEIGHT));
                end
            end
            send_word(w);
            if (w.action != ACT_SPARE_LO && w.action != ACT_SPARE_HI) counted++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run took %0d words (%0d line sends, %0d pixel reads, %0d store sweeps)",
                 sb.words_noted, sb.line_sends, sb.pixel_reads, sb.store_sweeps);
        $display("and checked %0d results; %0d mismatches, %0d results outstanding.",
                 sb.results_seen, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mlfs_pkg.sv
rtl/mlfs_front.sv
rtl/mlfs_queue.sv
rtl/mlfs_back.sv
rtl/memory_lcd_framebuffer_serializer.sv
dv/memory_lcd_framebuffer_serializer_tb.sv
